@@ design/lpd_pkg.sv @@
`timescale 1ns / 1ps

package lpd_pkg;

  // Field and register widths
  localparam int LEN_W      = 31;
  localparam int ACCUM_W    = 24;
  localparam int CNT_W      = 2;
  localparam int DATA_W     = 32;
  localparam int PADDR_W    = 3;

  localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 31'd65536;

  // Header byte positions of the little-endian length
  localparam logic [CNT_W-1:0] HDR_POS_B0 = 2'd0;
  localparam logic [CNT_W-1:0] HDR_POS_B1 = 2'd1;
  localparam logic [CNT_W-1:0] HDR_POS_B2 = 2'd2;
  localparam logic [CNT_W-1:0] HDR_POS_B3 = 2'd3;

  // Input opcodes
  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_CLOSE = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Register index (byte address / 4)
  localparam logic REG_MAX_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CLOSED  = 2'd2
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic       last;
  } result_t;

endpackage

@@ design/length_prefix_deframer.sv @@
`timescale 1ns / 1ps
// An input transaction passes the input register, then the result register, before
// out_valid rises; out_ready holding the result register delays the result further.
// Throughput: one transaction per cycle while out_ready does not hold the result
// register, as the parser updates once per accepted transaction.
// Reset (rst, synchronous): clears both pipeline registers and the parser to the
// header phase; max_length returns to 65536.

module length_prefix_deframer
  import lpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               opcode,
  input  logic [7:0]         data_byte,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic [7:0]         payload_byte,
  output logic               last,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic [LEN_W-1:0] max_length;
  logic             q_valid;
  logic             q_opcode;
  logic [7:0]       q_byte;
  logic             advance;
  logic             fire;
  result_t          res;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[PADDR_W-1] == REG_MAX_LENGTH) begin
      max_length <= pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1] == REG_MAX_LENGTH) begin
      prdata = {1'b0, max_length};
    end
  end

  // Pipeline control
  assign advance  = !out_valid || out_ready;
  assign fire     = q_valid && advance;
  assign in_ready = !q_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_opcode <= opcode;
      q_byte   <= data_byte;
    end
  end

  lpd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .opcode     (q_opcode),
    .data_byte  (q_byte),
    .max_length (max_length),
    .res        (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind         <= res.kind;
      payload_byte <= res.payload_byte;
      last         <= res.last;
    end
  end

endmodule

@@ design/lpd_parser.sv @@
`timescale 1ns / 1ps

module lpd_parser
  import lpd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic             opcode,
  input  logic [7:0]       data_byte,
  input  logic [LEN_W-1:0] max_length,
  output result_t          res
);

  phase_t             phase, phase_next;
  logic [CNT_W-1:0]   header_count, header_count_next;
  logic [ACCUM_W-1:0] length_accum, length_accum_next;
  logic [LEN_W-1:0]   bytes_remaining, bytes_remaining_next;

  logic [31:0] full_len;
  logic        hdr_done;
  logic        len_over;
  logic        len_zero;
  logic        pay_last;

  // Header decode on the fourth byte
  assign full_len = {data_byte, length_accum};
  assign hdr_done = (header_count == HDR_POS_B3);
  assign len_over = (full_len > {1'b0, max_length});
  assign len_zero = (full_len == 32'd0);
  assign pay_last = (bytes_remaining <= 31'd1);

  // Next state
  always_comb begin
    phase_next           = phase;
    header_count_next    = header_count;
    length_accum_next    = length_accum;
    bytes_remaining_next = bytes_remaining;
    if (opcode == OP_CLOSE) begin
      phase_next           = PH_HEADER;
      header_count_next    = '0;
      length_accum_next    = '0;
      bytes_remaining_next = '0;
    end else begin
      unique case (phase)
        PH_HEADER: begin
          if (!hdr_done) begin
            header_count_next = header_count + 2'd1;
            case (header_count)
              HDR_POS_B0: length_accum_next[7:0]   = data_byte;
              HDR_POS_B1: length_accum_next[15:8]  = data_byte;
              HDR_POS_B2: length_accum_next[23:16] = data_byte;
              default:    length_accum_next        = length_accum;
            endcase
          end else begin
            header_count_next = '0;
            length_accum_next = '0;
            if (len_over) begin
              phase_next           = PH_CLOSED;
              bytes_remaining_next = '0;
            end else if (!len_zero) begin
              phase_next           = PH_PAYLOAD;
              bytes_remaining_next = full_len[LEN_W-1:0];
            end
          end
        end
        PH_PAYLOAD: begin
          if (pay_last) begin
            phase_next           = PH_HEADER;
            bytes_remaining_next = '0;
          end else begin
            bytes_remaining_next = bytes_remaining - 31'd1;
          end
        end
        default: begin
          // closed: bytes are dropped
          phase_next = phase;
        end
      endcase
    end
  end

  // Result for the current transaction
  always_comb begin
    res = '{valid: 1'b0, kind: KIND_PAYLOAD, payload_byte: 8'd0, last: 1'b0};
    if (opcode == OP_DATA) begin
      unique case (phase)
        PH_HEADER: begin
          if (hdr_done && len_over) begin
            res.valid = 1'b1;
            res.kind  = KIND_ERROR;
            res.last  = 1'b1;
          end else if (hdr_done && len_zero) begin
            res.valid = 1'b1;
            res.kind  = KIND_EMPTY;
            res.last  = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          res.valid        = 1'b1;
          res.kind         = KIND_PAYLOAD;
          res.payload_byte = data_byte;
          res.last         = pay_last;
        end
        default: begin
          res.valid = 1'b0;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_count    <= '0;
      length_accum    <= '0;
      bytes_remaining <= '0;
    end else if (fire) begin
      phase           <= phase_next;
      header_count    <= header_count_next;
      length_accum    <= length_accum_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule

@@ design/lpd_checker.sv @@
`timescale 1ns / 1ps

module lpd_checker
  import lpd_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         kind,
  input logic [7:0]         payload_byte,
  input logic               last,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [DATA_W-1:0]  pwdata,
  input logic [DATA_W-1:0]  prdata,
  input logic               pready
);

  // A pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(payload_byte)
      && $stable(last))
    else $error("result changed while stalled");

  // Empty and error results close a message and carry no byte
  a_non_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_PAYLOAD |-> last && payload_byte == 8'd0)
    else $error("non-payload result malformed");

  // Kind code 3 is never produced
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind == KIND_PAYLOAD || kind == KIND_EMPTY || kind == KIND_ERROR)
    else $error("illegal result kind");

  // A write to max_length reads back masked to 31 bits
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && paddr[PADDR_W-1] == REG_MAX_LENGTH
      ##1 paddr[PADDR_W-1] == REG_MAX_LENGTH
    |-> prdata == {1'b0, $past(pwdata[LEN_W-1:0])})
    else $error("max_length readback mismatch");

endmodule

bind length_prefix_deframer lpd_checker u_lpd_checker (.*);

@@ tb/deframe_monitor.sv @@
`timescale 1ns / 1ps

module deframe_monitor
  import lpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               opcode,
  input  logic [7:0]         data_byte,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         kind,
  input  logic [7:0]         payload_byte,
  input  logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  input  logic [DATA_W-1:0]  prdata,
  input  logic               pready,
  input  logic               end_check,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } deframe_result_t;

  // Shadow of the parser state and the length limit
  phase_t            parse_phase;
  logic [CNT_W-1:0]  hdr_count;
  logic [31:0]       len_accum;
  logic [LEN_W-1:0]  payload_left;
  logic [LEN_W-1:0]  max_len;

  deframe_result_t   results_due[$];

  function automatic void restart_parser();
    parse_phase  = PH_HEADER;
    hdr_count    = HDR_POS_B0;
    len_accum    = '0;
    payload_left = '0;
  endfunction

  // Advance the shadow parser by one input transaction
  function automatic void deframe_step(input logic op, input logic [7:0] b,
                                       output bit emit, output deframe_result_t r);
    logic [31:0] len;
    emit = 1'b0;
    r    = '0;
    if (op == OP_CLOSE) begin
      restart_parser();
      return;
    end
    case (parse_phase)
      PH_HEADER: begin
        len = len_accum | ({24'd0, b} << (8 * hdr_count));
        if (hdr_count != HDR_POS_B3) begin
          len_accum = len;
          hdr_count = hdr_count + 1'b1;
        end else begin
          len_accum = '0;
          hdr_count = HDR_POS_B0;
          if (len > {1'b0, max_len}) begin
            // oversize: report once, then drop everything until a close
            parse_phase  = PH_CLOSED;
            payload_left = '0;
            emit         = 1'b1;
            r.kind       = KIND_ERROR;
            r.last       = 1'b1;
          end else if (len == 32'd0) begin
            emit   = 1'b1;
            r.kind = KIND_EMPTY;
            r.last = 1'b1;
          end else begin
            payload_left = len[LEN_W-1:0];
            parse_phase  = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        emit   = 1'b1;
        r.kind = KIND_PAYLOAD;
        r.data = b;
        r.last = (payload_left <= 1);
        if (r.last) begin
          payload_left = '0;
          parse_phase  = PH_HEADER;
        end else begin
          payload_left = payload_left - 1'b1;
        end
      end
      default: ;  // closed: byte dropped
    endcase
  endfunction

  function automatic void report_result(string what, deframe_result_t exp_r,
                                        deframe_result_t got_r);
    fail_count++;
    if (fail_count <= 10)
      $display("[%0t] %s: expected kind=%0d data=%02h last=%0b, got kind=%0d data=%02h last=%0b",
               $time, what, exp_r.kind, exp_r.data, exp_r.last,
               got_r.kind, got_r.data, got_r.last);
  endfunction

  always @(posedge clk) begin : watch
    bit              emit;
    deframe_result_t exp_r;
    deframe_result_t got_r;
    if (rst) begin
      restart_parser();
      max_len    = MAX_LENGTH_RESET;
      fail_count = 0;
      results_due.delete();
    end else begin
      // config port: register reads are checked, writes update the shadow limit
      if (psel && penable && pready && (paddr >> 2) == REG_MAX_LENGTH) begin
        if (pwrite) begin
          max_len = pwdata[LEN_W-1:0];
        end else if (prdata !== {1'b0, max_len}) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] max_length read: expected %08h, got %08h",
                     $time, {1'b0, max_len}, prdata);
        end
      end

      // input transaction
      if (in_valid && in_ready) begin
        deframe_step(opcode, data_byte, emit, exp_r);
        if (emit) results_due.push_back(exp_r);
      end

      // output transaction
      if (out_valid && out_ready) begin
        got_r.kind = kind;
        got_r.data = payload_byte;
        got_r.last = last;
        if (results_due.size() == 0) begin
          report_result("result with none expected", '0, got_r);
        end else begin
          exp_r = results_due.pop_front();
          if (got_r.kind !== exp_r.kind || got_r.data !== exp_r.data ||
              got_r.last !== exp_r.last)
            report_result("result mismatch", exp_r, got_r);
        end
      end

      // leftovers at end of test
      if (end_check && results_due.size() != 0) begin
        if (fail_count < 10)
          $display("[%0t] %0d expected results never arrived", $time, results_due.size());
        fail_count += results_due.size();
      end
    end
    pending = results_due.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import lpd_pkg::*;

  localparam logic [PADDR_W-1:0] MAX_ADDR     = PADDR_W'(REG_MAX_LENGTH) << 2;
  localparam logic [PADDR_W-1:0] UNUSED_ADDR  = PADDR_W'(1) << 2;
  localparam int                 STALL_CYCLES = 100;
  localparam int                 PHASE_ITEMS  = 60;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               opcode;
  logic [7:0]         data_byte;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         kind;
  logic [7:0]         payload_byte;
  logic               last;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               end_check;
  int                 fail_count;
  int                 pending;

  int send_idle_pct;
  int recv_idle_pct;
  int stall_req;
  int items_sent;

  length_prefix_deframer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
    .payload_byte(payload_byte), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  deframe_monitor monitor (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
    .payload_byte(payload_byte), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .end_check(end_check), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: random back-pressure, plus a long hold-off whenever one is requested
  initial begin : sink
    int hold_left;
    int seen_req;
    hold_left = 0;
    seen_req  = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (seen_req != stall_req) begin
        seen_req  = stall_req;
        hold_left = STALL_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // One input transaction; valid stays up between back-to-back items
  task automatic send_item(input logic op, input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Little-endian 4-byte length prefix
  task automatic send_header(input logic [31:0] len);
    send_item(OP_DATA, len[7:0]);
    send_item(OP_DATA, len[15:8]);
    send_item(OP_DATA, len[23:16]);
    send_item(OP_DATA, len[31:24]);
  endtask

  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stop sending and let the pipeline empty out
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Mostly complete frames; the rest are cut frames, random lengths and stray closes
  task automatic random_frame(input logic [LEN_W-1:0] cap);
    int          pick;
    int          n;
    logic [31:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      len = 32'($urandom_range(0, 10));
      send_header(len);
      if (len > {1'b0, cap}) begin
        n = $urandom_range(0, 3);
        repeat (n) send_item(OP_DATA, 8'($urandom));
        send_item(OP_CLOSE, 8'($urandom));
      end else begin
        repeat (len) send_item(OP_DATA, 8'($urandom));
      end
    end else if (pick < 75) begin
      send_header($urandom);
      n = $urandom_range(0, 5);
      repeat (n) send_item(OP_DATA, 8'($urandom));
      send_item(OP_CLOSE, 8'($urandom));
    end else if (pick < 85) begin
      n = $urandom_range(1, 3);
      repeat (n) send_item(OP_DATA, 8'($urandom));
      send_item(OP_CLOSE, 8'($urandom));
    end else if (pick < 95) begin
      len = 32'($urandom_range(2, 10));
      send_header(len);
      n = $urandom_range(0, len - 1);
      repeat (n) send_item(OP_DATA, 8'($urandom));
      send_item(OP_CLOSE, 8'($urandom));
    end else begin
      send_item(OP_CLOSE, 8'($urandom));
    end
  endtask

  initial begin : stimulus
    logic [DATA_W-1:0] new_max;
    int                start;
    rst           = 1'b1;
    in_valid      = 1'b0;
    opcode        = OP_DATA;
    data_byte     = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    end_check     = 1'b0;
    stall_req     = 0;
    items_sent    = 0;
    send_idle_pct = 11;
    recv_idle_pct = 59;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset limit: empty message, one-byte message, oversize with a dropped byte
    apb_access(1'b0, MAX_ADDR, '0);
    send_header(32'd0);
    send_header(32'd1);
    send_item(OP_DATA, 8'hFF);
    send_header(32'h0001_0001);
    send_item(OP_DATA, 8'hA5);
    send_item(OP_CLOSE, 8'h00);
    wait_idle();

    // bit 31 is masked off, the write past the register list is ignored
    apb_access(1'b1, MAX_ADDR, 32'h8000_0003);
    apb_access(1'b1, UNUSED_ADDR, 32'h0000_0000);
    apb_access(1'b0, MAX_ADDR, '0);
    // length equal to the limit, then a header cut by a close
    send_header(32'd3);
    send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'h80);
    send_item(OP_DATA, 8'h7F);
    send_item(OP_DATA, 8'h12);
    send_item(OP_DATA, 8'h34);
    send_item(OP_CLOSE, 8'hFF);

    // random phases over several limits and idling patterns
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      send_idle_pct = (p < 2) ? 11 : (p < 4) ? 59 : 0;
      recv_idle_pct = (p < 2) ? 59 : (p < 4) ? 11 : 0;
      if (p == 0) stall_req++;
      case (p)
        0:       new_max = 32'hFFFF_FFFF;
        1:       new_max = 32'd0;
        2:       new_max = 32'($urandom_range(1, 16));
        3:       new_max = 32'd8;
        4:       new_max = 32'($urandom_range(17, 300));
        default: new_max = 32'd12;
      endcase
      apb_access(1'b1, MAX_ADDR, new_max);
      apb_access(1'b0, MAX_ADDR, '0);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) random_frame(new_max[LEN_W-1:0]);
    end

    wait_idle();
    @(negedge clk);
    end_check <= 1'b1;
    @(negedge clk);
    end_check <= 1'b0;
    @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ files.f @@
design/lpd_pkg.sv
design/lpd_parser.sv
design/length_prefix_deframer.sv
design/lpd_checker.sv
tb/deframe_monitor.sv
tb/tb.sv
